// ===== src/bfa_pkg.sv =====
`timescale 1ns / 1ps

package bfa_pkg;

  // Pool geometry
  localparam int POOL_UNITS = 4096;
  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = 5;
  localparam int MAP_WORDS  = (POOL_UNITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int UNIT_W     = WORD_W + BIT_W;

  // Field widths
  localparam int LEN_W      = 13;
  localparam int START_W    = 12;
  localparam int ADDR_W     = 32;
  localparam int SPAN_W     = ((UNIT_W > LEN_W) ? UNIT_W : LEN_W) + 1;

  // Units past the end of the pool in the top word count as used
  localparam int LAST_BITS  = POOL_UNITS - WORD_BITS * (MAP_WORDS - 1);
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    (LAST_BITS == WORD_BITS) ? '1 : ((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));

  localparam logic [ADDR_W-1:0] FAIL_ADDRESS    = 32'hCAFE_BABE;
  localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'd6407964;

  // Register map
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_POOL_BASE = 3'd0;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_W-1:0]    word_idx_t;
  typedef logic [BIT_W-1:0]     bit_idx_t;
  typedef logic [UNIT_W-1:0]    unit_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [START_W-1:0]   start_unit_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  // Outcome of evaluating one map word
  typedef struct packed {
    logic     hit;
    bit_idx_t hit_bit;
    len_t     run_out;
  } scan_res_t;

endpackage

// ===== src/bfa_used_map.sv =====
`timescale 1ns / 1ps

module bfa_used_map (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  bfa_pkg::word_idx_t rd_addr,
  output bfa_pkg::word_t   rd_data,
  input  logic             wr_en,
  input  bfa_pkg::word_idx_t wr_addr,
  input  bfa_pkg::word_t   wr_data
);
  import bfa_pkg::*;

  word_t                mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld;
  word_t                rdata_q;
  logic                 rvld_q;

  // Row valid bits: an unwritten row reads as all free
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      rvld_q  <= vld[rd_addr];
    end
  end

  assign rd_data = rvld_q ? rdata_q : '0;

endmodule

// ===== src/bfa_word_scan.sv =====
`timescale 1ns / 1ps

module bfa_word_scan (
  input  bfa_pkg::word_t    word,
  input  logic              last,
  input  bfa_pkg::len_t     run_in,
  input  bfa_pkg::len_t     len,
  output bfa_pkg::scan_res_t res
);
  import bfa_pkg::*;

  word_t                      free;
  word_t                      used;
  word_t                      prefix;
  word_t                      thresh;
  word_t                      win;
  word_t                      hits;
  word_t                      lowest;
  word_t                      rev;
  word_t                      rused;
  word_t                      tprefix;
  word_t [5:0]                pw;
  len_t                       need_m1;
  logic [5:0]                 sh;
  logic [5:0]                 top_run;
  bit_idx_t                   bit_idx;

  always_comb begin
    free = ~word;
    if (last) begin
      free = free & LAST_MASK;
    end
    used = ~free;

    // Free bits below the lowest used bit: continue the run carried in
    prefix  = ~used & (used - 1'b1);
    need_m1 = len - run_in - 1'b1;
    thresh  = (need_m1 < len_t'(WORD_BITS)) ? ('1 << need_m1[BIT_W-1:0]) : '0;

    // Windows of 1,2,4,...,32 free bits ending at each position
    pw[0] = free;
    for (int k = 1; k < 6; k++) begin
      pw[k] = pw[k-1] & (pw[k-1] << (1 << (k-1)));
    end

    // Window of exactly len free bits, built from the binary digits of len
    win = '1;
    for (int k = 0; k < 6; k++) begin
      sh = len[5:0] & ((6'd1 << k) - 6'd1);
      if (len[k]) begin
        win = win & (pw[k] << sh);
      end
    end
    if (len > len_t'(WORD_BITS)) begin
      win = '0;
    end

    hits   = (prefix & thresh) | win;
    lowest = hits & (~hits + 1'b1);

    bit_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        bit_idx = bit_idx | bit_idx_t'(i);
      end
    end

    // Free run at the top of the word, carried into the next word
    for (int i = 0; i < WORD_BITS; i++) begin
      rev[i] = free[WORD_BITS-1-i];
    end
    rused   = ~rev;
    tprefix = ~rused & (rused - 1'b1);
    top_run = 6'($countones(tprefix));

    res.hit     = |hits;
    res.hit_bit = bit_idx;
    res.run_out = (free == '1) ? (run_in + len_t'(WORD_BITS)) : len_t'(top_run);
  end

endmodule

// ===== src/bitmap_first_fit_allocator.sv =====
`timescale 1ns / 1ps

// Chan    Dir  Signals                                                Transfer when
// request in   in_valid, in_ready, request_length                    in_valid & in_ready
// result  out  out_valid, out_ready, granted, start_unit, block_address out_valid & out_ready
// config  in   psel, penable, pwrite, paddr, pwdata, prdata, pready  psel & penable & pwrite
//
// Zero or oversized lengths go straight to FIN; otherwise the W = 128 map words
// are scanned in order and, on a grant, each word that the run covers is read back
// and marked before FIN. The map RAM read port (one word a cycle) and the single
// word-scan unit set the pace.
// Reset is synchronous; the map needs no clearing pass, row valid bits make every
// unit free at once. The result sits in an output register, so a new request is
// taken while a result waits; a finished request holds in FIN until the output register is free.

module bitmap_first_fit_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bfa_pkg::len_t                request_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         granted,
  output bfa_pkg::start_unit_t         start_unit,
  output bfa_pkg::addr_t               block_address,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfa_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bfa_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    MARK_RD,
    MARK,
    FIN
  } state_t;

  state_t     state;
  addr_t      pool_base;
  len_t       len_q;
  len_t       run_q;
  word_idx_t  scan_word;
  word_idx_t  mark_word;
  unit_t      start_q;
  unit_t      end_q;
  logic       res_granted;

  // map port controls
  logic       rd_en;
  word_idx_t  rd_addr;
  word_t      map_rdata;
  logic       wr_en;
  word_idx_t  wr_addr;
  word_t      wr_data;
  word_t      mark_mask;
  bit_idx_t   mark_lo;
  bit_idx_t   mark_hi;

  scan_res_t  scan;
  logic       last_word;
  logic       len_ok;
  logic       cfg_wr;
  unit_t      hit_pos;
  logic [SPAN_W-1:0] span;
  word_idx_t  start_word;
  word_idx_t  end_word;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == REG_POOL_BASE) ? pool_base : '0;

  assign in_ready  = (state == IDLE);
  assign last_word = (scan_word == word_idx_t'(MAP_WORDS - 1));
  assign len_ok    = (request_length != '0) &&
                     (32'(request_length) <= 32'(POOL_UNITS));

  // Run start from the unit at which the run reached its length
  assign hit_pos    = {scan_word, scan.hit_bit};
  assign span       = SPAN_W'(hit_pos) + SPAN_W'(1) - SPAN_W'(len_q);
  assign start_word = start_q[UNIT_W-1:BIT_W];
  assign end_word   = end_q[UNIT_W-1:BIT_W];

  bfa_word_scan u_scan (
    .word   (map_rdata),
    .last   (last_word),
    .run_in (run_q),
    .len    (len_q),
    .res    (scan)
  );

  bfa_used_map u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (map_rdata),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Bits of the run that fall in the word being marked
  always_comb begin
    mark_lo   = (mark_word == start_word) ? start_q[BIT_W-1:0] : '0;
    mark_hi   = (mark_word == end_word)   ? end_q[BIT_W-1:0]   : '1;
    mark_mask = ('1 << mark_lo) & ('1 >> (bit_idx_t'(WORD_BITS - 1) - mark_hi));
  end

  // Map read/write sequencing
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_word;
    wr_en   = 1'b0;
    wr_addr = mark_word;
    wr_data = map_rdata | mark_mask;
    unique case (state)
      IDLE: begin
        if (in_valid && len_ok) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      SCAN: begin
        if (!scan.hit && !last_word) begin
          rd_en   = 1'b1;
          rd_addr = scan_word + 1'b1;
        end
      end
      MARK_RD: begin
        rd_en   = 1'b1;
        rd_addr = start_word;
      end
      MARK: begin
        wr_en = 1'b1;
        if (mark_word != end_word) begin
          rd_en   = 1'b1;
          rd_addr = mark_word + 1'b1;
        end
      end
      FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      pool_base <= POOL_BASE_RESET;
    end else begin
      if (cfg_wr && (paddr == REG_POOL_BASE)) begin
        pool_base <= pwdata;
      end
      // Load a new result from FIN, else drop valid once the result transfers
      if ((state == FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            len_q       <= request_length;
            run_q       <= '0;
            scan_word   <= '0;
            start_q     <= '0;
            res_granted <= 1'b0;
            state       <= len_ok ? SCAN : FIN;
          end
        end
        SCAN: begin
          if (scan.hit) begin
            start_q     <= unit_t'(span);
            end_q       <= hit_pos;
            res_granted <= 1'b1;
            state       <= MARK_RD;
          end else if (last_word) begin
            state <= FIN;
          end else begin
            run_q     <= scan.run_out;
            scan_word <= scan_word + 1'b1;
          end
        end
        MARK_RD: begin
          mark_word <= start_word;
          state     <= MARK;
        end
        MARK: begin
          if (mark_word == end_word) begin
            state <= FIN;
          end else begin
            mark_word <= mark_word + 1'b1;
          end
        end
        FIN: begin
          if (!out_valid || out_ready) begin
            granted       <= res_granted;
            start_unit    <= start_unit_t'(start_q);
            block_address <= res_granted ? (pool_base + addr_t'(start_q)) : FAIL_ADDRESS;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/bfa_checker.sv =====
`timescale 1ns / 1ps

module bfa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input bfa_pkg::len_t                request_length,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         granted,
  input bfa_pkg::start_unit_t         start_unit,
  input bfa_pkg::addr_t               block_address,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [bfa_pkg::PADDR_W-1:0]  paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata,
  input logic                         pready
);
  import bfa_pkg::*;

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // one request at a time: busy right after a request transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after request transfer");

  // failures carry the marker address and unit zero
  a_fail_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> block_address == FAIL_ADDRESS && start_unit == '0)
    else $error("bad failure result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted) &&
      $stable(start_unit) && $stable(block_address))
    else $error("stalled result changed");

endmodule

bind bitmap_first_fit_allocator bfa_checker u_bfa_checker (.*);
